@@ sv/clxm_pkg.sv @@
// Package for the combined LCG / xorshift / multiply-with-carry generator.
// Holds the generator constants and the controller-to-datapath command struct.
// No dependencies.
package clxm_pkg;

    // Generator constants
    localparam logic [63:0] LCG_MUL = 64'd2862933555777941757;
    localparam logic [63:0] LCG_ADD = 64'd7046029254386353087;
    localparam logic [63:0] XS_INIT = 64'd4101842887655102017;
    localparam logic [31:0] MWC_MUL = 32'd4294957665;

    // Commands from controller to datapath, at most one set per cycle
    typedef struct packed {
        logic init_seed;  // load the LCG word from the seed register, the other two with constants
        logic mul;        // register the partial products
        logic upd;        // advance the three words
        logic copy_xs;    // xorshift word takes the LCG word
        logic copy_mwc;   // MWC word takes the xorshift word
        logic load_out;   // register the result from the current words
    } clxm_cmd_t;

endpackage

@@ sv/clxm_if.sv @@
// Handshake channels of the generator: request channel and result channel.
// Depends on nothing.
interface clxm_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink (input valid, input reseed, output ready);
endinterface

interface clxm_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);
endinterface

@@ sv/clxm_datapath.sv @@
// Datapath of the generator: seed register, the three state words, the
// split 64-bit multiply, the tempering and the result register.
// Depends on clxm_pkg.
module clxm_datapath
    import clxm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_wr_en,
    input  logic [63:0] seed_wr_data,
    input  clxm_cmd_t   cmd,
    output logic [63:0] random_value
);

    logic [63:0] seed_reg;
    logic [63:0] lcg_reg, lcg_next;
    logic [63:0] xs_reg, xs_next;
    logic [63:0] mwc_reg, mwc_next;
    logic [63:0] p_ll_reg;      // low x low product of the LCG multiply
    logic [31:0] p_cross_reg;   // sum of the two cross products, low half only
    logic [63:0] p_mwc_reg;     // MWC multiply
    logic [63:0] res_reg, res_next;

    logic [31:0] cross_a;
    logic [31:0] cross_b;
    logic [63:0] xs_s1;
    logic [63:0] xs_s2;
    logic [63:0] tmp_a;
    logic [63:0] tmp_b;
    logic [63:0] tmp_c;

    // Seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (seed_wr_en)
            seed_reg <= seed_wr_data;
    end

    // Partial products: four independent 32x32 multipliers
    assign cross_a = lcg_reg[31:0] * LCG_MUL[63:32];
    assign cross_b = lcg_reg[63:32] * LCG_MUL[31:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p_ll_reg    <= {32'd0, lcg_reg[31:0]} * {32'd0, LCG_MUL[31:0]};
            p_cross_reg <= cross_a + cross_b;
            p_mwc_reg   <= {32'd0, mwc_reg[31:0]} * {32'd0, MWC_MUL};
        end
    end

    // Xorshift steps
    assign xs_s1 = xs_reg ^ (xs_reg >> 17);
    assign xs_s2 = xs_s1 ^ (xs_s1 << 31);

    // State word update
    always_comb
    begin
        lcg_next = lcg_reg;
        xs_next  = xs_reg;
        mwc_next = mwc_reg;
        if (cmd.init_seed)
        begin
            xs_next  = XS_INIT;
            mwc_next = 64'd1;
            lcg_next = seed_reg ^ XS_INIT;
        end
        else if (cmd.upd)
        begin
            lcg_next = p_ll_reg + {p_cross_reg, 32'd0} + LCG_ADD;
            xs_next  = xs_s2 ^ (xs_s2 >> 8);
            mwc_next = p_mwc_reg + {32'd0, mwc_reg[63:32]};
        end
        else if (cmd.copy_xs)
            xs_next = lcg_reg;
        else if (cmd.copy_mwc)
            mwc_next = xs_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg <= '0;
            xs_reg  <= '0;
            mwc_reg <= '0;
        end
        else
        begin
            lcg_reg <= lcg_next;
            xs_reg  <= xs_next;
            mwc_reg <= mwc_next;
        end
    end

    // Tempering of the LCG word and result mix
    assign tmp_a    = lcg_reg ^ (lcg_reg << 21);
    assign tmp_b    = tmp_a ^ (tmp_a >> 35);
    assign tmp_c    = tmp_b ^ (tmp_b << 4);
    assign res_next = (tmp_c + xs_reg) ^ mwc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            res_reg <= res_next;
    end

    assign random_value = res_reg;

endmodule

@@ sv/clxm_ctrl.sv @@
// Controller of the generator: request handshake, seeding sequence,
// draw phases and result valid flag.
// Depends on clxm_pkg.
module clxm_ctrl
    import clxm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_reseed,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output clxm_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SINIT = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_SETX  = 3'd4;
    localparam logic [2:0] S_SETM  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Seeding draw counts after which a word copy or the end follows
    localparam logic [2:0] CNT_COPY_XS  = 3'd1;
    localparam logic [2:0] CNT_COPY_MWC = 3'd3;
    localparam logic [2:0] CNT_DONE     = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] cnt_inc;
    logic       seeding_reg, seeding_next;
    logic       pending_reg, pending_next;
    logic       out_valid_reg, out_valid_next;

    assign cnt_inc = cnt_reg + 3'd1;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        seeding_next   = seeding_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_reseed || pending_reg)
                    begin
                        state_next   = S_SINIT;
                        seeding_next = 1'b1;
                        pending_next = 1'b0;
                    end
                    else
                        state_next = S_MUL;
                end
            end
            S_SINIT:
            begin
                cmd.init_seed = 1'b1;
                cnt_next      = '0;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (seeding_reg)
                begin
                    cnt_next = cnt_inc;
                    case (cnt_inc)
                        CNT_COPY_XS:  state_next = S_SETX;
                        CNT_COPY_MWC: state_next = S_SETM;
                        CNT_DONE:
                        begin
                            seeding_next = 1'b0;
                            state_next   = S_MUL;
                        end
                        default:      state_next = S_MUL;
                    endcase
                end
                else
                    state_next = S_OUT;
            end
            S_SETX:
            begin
                cmd.copy_xs = 1'b1;
                state_next  = S_MUL;
            end
            S_SETM:
            begin
                cmd.copy_mwc = 1'b1;
                state_next   = S_MUL;
            end
            S_OUT:
            begin
                // wait for the result register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            seeding_reg   <= 1'b0;
            pending_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seeding_reg   <= seeding_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ sv/combined_lcg_xorshift_mwc_rng_top.sv @@
// Top level of the combined LCG / xorshift / multiply-with-carry generator.
// Depends on clxm_pkg, clxm_if, clxm_ctrl and clxm_datapath.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+---------------------------
//  req      | in  | valid / ready     | reseed (1 bit)
//  rsp      | out | valid / ready     | random_value (64 bits)
//  seed     | in  | seed_wr_en        | seed_wr_data (64 bits)
//
// A draw registers the 32x32 partial products, then advances the three
// words. A plain item runs through accept, multiply, update and result
// load before the next ready; an item that seeds adds one seed load, five
// extra draws and two word copies.
// After reset the first item always seeds. One item is in work at a time;
// a result waits in the output register while the next item is taken, and
// the block holds in the result-load step if that register is still full.
module combined_lcg_xorshift_mwc_rng_top
    import clxm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_wr_en,
    input  logic [63:0] seed_wr_data,
    clxm_req_if.sink    req,
    clxm_rsp_if.source  rsp
);

    clxm_cmd_t cmd;
    logic      req_ready;
    logic      rsp_valid;

    // Controller
    clxm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_reseed (req.reseed),
        .in_ready  (req_ready),
        .out_valid (rsp_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Datapath
    clxm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .cmd          (cmd),
        .random_value (rsp.random_value)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

endmodule

@@ sv/clxm_checker.sv @@
// Port-level checker for the generator top level, attached by bind.
// Depends on combined_lcg_xorshift_mwc_rng_top.
module clxm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] random_value
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(random_value))
        else $error("result changed while stalled");

    // One item at a time: no new item right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while another is in work");

    // A new result needs at least the multiply and update steps
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared too early");

endmodule

bind combined_lcg_xorshift_mwc_rng_top clxm_checker u_clxm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .random_value (rsp.random_value)
);
